/* src/cdq_pkg.sv */
package cdq_pkg;

  localparam logic [1:0] ACT_PUSH_REAR  = 2'd0;
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_W = 8;

  typedef struct packed {
    logic [1:0] status;
    logic       now_empty;
    logic       now_full;
    logic       pop_ok;
  } cdq_res_t;

endpackage

/* src/cdq_ram.sv */
module cdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/cdq_ctrl.sv */
module cdq_ctrl import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [1:0]               action,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  output logic                     strobe,
  output cdq_res_t                 res
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic          strobe_r;
  cdq_res_t      res_r, res_nxt;

  logic [PW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_nxt_inc;
  logic          empty, full, is_push;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - 1'b1;

  assign empty   = (head_r == tail_r);
  assign full    = (tail_inc == head_r);
  assign is_push = (action == ACT_PUSH_REAR) || (action == ACT_PUSH_FRONT);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_inc;
    mem_re     = 1'b0;
    mem_raddr  = head_inc;
    res_nxt    = '0;
    res_nxt.status = ST_OK;
    if (accept) begin
      unique case (action)
        ACT_PUSH_REAR: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            tail_nxt  = tail_inc;
            mem_we    = 1'b1;
            mem_waddr = tail_inc;
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            head_nxt  = head_dec;
            mem_we    = 1'b1;
            mem_waddr = head_r;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            head_nxt       = head_inc;
            mem_re         = 1'b1;
            mem_raddr      = head_inc;
            res_nxt.pop_ok = 1'b1;
          end
        end
        ACT_POP_REAR: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            tail_nxt       = tail_dec;
            mem_re         = 1'b1;
            mem_raddr      = tail_r;
            res_nxt.pop_ok = 1'b1;
          end
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
    end
    tail_nxt_inc      = (tail_nxt == LAST) ? '0 : tail_nxt + 1'b1;
    res_nxt.now_empty = (head_nxt == tail_nxt);
    res_nxt.now_full  = (tail_nxt_inc == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      strobe_r <= 1'b0;
      res_r    <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      strobe_r <= accept;
      res_r    <= res_nxt;
    end
  end

  assign strobe = strobe_r;
  assign res    = res_r;

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(empty && full))
    else $error("ring reports empty and full at once");

  a_reject_holds_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((is_push && full) || (!is_push && empty))
      |=> $stable(head_r) && $stable(tail_r))
    else $error("rejected beat moved a pointer");

  a_pop_reads_mem: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_push && !empty |-> mem_re && !mem_we)
    else $error("accepted pop did not read the ring");

  a_push_writes_mem: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_push && !full |-> mem_we && !mem_re)
    else $error("accepted push did not write the ring");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> strobe_r && (res_r.pop_ok == (res_r.status == ST_OK && !$past(is_push))))
    else $error("result beat does not match accepted beat");

endmodule

/* src/circular_deque.sv */
// Ring-buffer double-ended queue of bytes with DEPTH slots holding at most
// DEPTH-1 entries. Every accepted beat (start high, busy low) pushes or pops
// at either end and returns exactly one result beat, marked by out_strobe,
// in the cycle after acceptance; the receiver cannot stall it. busy stays low,
// so a new beat may be accepted every cycle: each beat uses the memory
// once (a write port for a push, a registered read port for a pop) and
// the pointers advance in the same cycle. A push on a full queue or a pop
// on an empty one returns a full or empty status, a zero value, and leaves
// the queue unchanged. No clearing pass is needed after reset.
module circular_deque import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_item,
  output logic        out_strobe,
  output logic [7:0]  out_value,
  output logic [1:0]  out_status,
  output logic        out_now_empty,
  output logic        out_now_full
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic              accept;
  logic              mem_we, mem_re;
  logic [PW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  cdq_res_t          res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .strobe    (out_strobe),
    .res       (res)
  );

  cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_item),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_value     = res.pop_ok ? mem_rdata : '0;
  assign out_status    = res.status;
  assign out_now_empty = res.now_empty;
  assign out_now_full  = res.now_full;

endmodule

/* tb/deque_checker.sv */
module deque_checker import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_item,
  input  logic       out_strobe,
  input  logic [7:0] out_value,
  input  logic [1:0] out_status,
  input  logic       out_now_empty,
  input  logic       out_now_full,
  output int         fail_count,
  output int         pending,
  output int         full_rejects,
  output int         empty_rejects,
  output int         data_pops
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [PW-1:0] slot_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       now_empty;
    logic       now_full;
  } deque_beat_t;

  logic [7:0]  ring [DEPTH];
  slot_t       front_gap;
  slot_t       rear_last;
  deque_beat_t awaited_results [$];

  function automatic slot_t wrap_inc(slot_t p);
    return (p == slot_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic slot_t wrap_dec(slot_t p);
    return (p == '0) ? slot_t'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic deque_beat_t deque_step(logic [1:0] act, logic [7:0] val);
    deque_beat_t r;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH_REAR: begin
        if (wrap_inc(rear_last) == front_gap) begin
          r.status = ST_FULL;
        end else begin
          rear_last = wrap_inc(rear_last);
          ring[rear_last] = val;
        end
      end
      ACT_PUSH_FRONT: begin
        if (wrap_inc(rear_last) == front_gap) begin
          r.status = ST_FULL;
        end else begin
          ring[front_gap] = val;
          front_gap = wrap_dec(front_gap);
        end
      end
      ACT_POP_FRONT: begin
        if (front_gap == rear_last) begin
          r.status = ST_EMPTY;
        end else begin
          front_gap = wrap_inc(front_gap);
          r.value = ring[front_gap];
        end
      end
      default: begin
        if (front_gap == rear_last) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = ring[rear_last];
          rear_last = wrap_dec(rear_last);
        end
      end
    endcase
    r.now_empty = (front_gap == rear_last);
    r.now_full  = (wrap_inc(rear_last) == front_gap);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_beat_t want;
    deque_beat_t got;
    if (!rst_n) begin
      front_gap = '0;
      rear_last = '0;
      awaited_results.delete();
      pending       <= 0;
      fail_count    <= 0;
      full_rejects  <= 0;
      empty_rejects <= 0;
      data_pops     <= 0;
    end else begin
      if (start && !busy) begin
        want = deque_step(in_action, in_item);
        awaited_results.push_back(want);
        if (want.status == ST_FULL) full_rejects <= full_rejects + 1;
        if (want.status == ST_EMPTY) empty_rejects <= empty_rejects + 1;
        if (want.status == ST_OK && (in_action == ACT_POP_FRONT || in_action == ACT_POP_REAR))
          data_pops <= data_pops + 1;
      end
      if (out_strobe) begin
        got = {out_value, out_status, out_now_empty, out_now_full};
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing awaited: value=%h status=%0d empty=%b full=%b",
                   $time, out_value, out_status, out_now_empty, out_now_full);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected value=%h status=%0d empty=%b full=%b, got value=%h status=%0d empty=%b full=%b",
                     $time, want.value, want.status, want.now_empty, want.now_full,
                     got.value, got.status, got.now_empty, got.now_full);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= awaited_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import cdq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_BEATS = 700;
  localparam int IDLE_LIMIT   = 400;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_action;
  logic [7:0] in_item;
  logic       out_strobe;
  logic [7:0] out_value;
  logic [1:0] out_status;
  logic       out_now_empty;
  logic       out_now_full;

  int fails;
  int pending;
  int full_rejects;
  int empty_rejects;
  int data_pops;
  int beats_sent;
  int directed_beats;
  int idle_cycles;
  bit steady;

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_now_empty (out_now_empty),
    .out_now_full  (out_now_full)
  );

  deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_now_empty (out_now_empty),
    .out_now_full  (out_now_full),
    .fail_count    (fails),
    .pending       (pending),
    .full_rejects  (full_rejects),
    .empty_rejects (empty_rejects),
    .data_pops     (data_pops)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("circular_deque test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_beat(input logic [1:0] act, input logic [7:0] val);
    int gap;
    int r;
    start     <= 1'b1;
    in_action <= act;
    in_item   <= val;
    do @(posedge clk); while (busy);
    beats_sent++;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(4, 24);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    int push_pct;
    logic [1:0] act;
    idle_cycles = 0;
    beats_sent  = 0;
    steady      = 1'b0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_action <= ACT_PUSH_REAR;
    in_item   <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops, extreme bytes at both ends, fill to full, pushes on full, then pops at both ends
    drive_beat(ACT_POP_FRONT, 8'hFF);
    drive_beat(ACT_POP_REAR, 8'h00);
    drive_beat(ACT_PUSH_REAR, 8'h00);
    drive_beat(ACT_PUSH_FRONT, 8'hFF);
    drive_beat(ACT_PUSH_REAR, 8'hA5);
    drive_beat(ACT_PUSH_FRONT, 8'h5A);
    drive_beat(ACT_POP_FRONT, 8'h00);
    drive_beat(ACT_POP_REAR, 8'hFF);
    for (int k = 0; k < DEPTH - 3; k++)
      drive_beat(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_REAR, 8'(k * 17 + 3));
    drive_beat(ACT_PUSH_REAR, 8'h3C);
    drive_beat(ACT_PUSH_FRONT, 8'hC3);
    drive_beat(ACT_POP_REAR, 8'h81);
    drive_beat(ACT_POP_FRONT, 8'h7E);
    directed_beats = beats_sent;

    // bursts that lean toward filling, draining or neither
    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      burst = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        if ($urandom_range(1, 100) <= push_pct)
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        else
          act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
        drive_beat(act, 8'($urandom));
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d beats (%0d directed): %0d pops returned data,",
             beats_sent, directed_beats, data_pops);
    $display("%0d pushes hit full, %0d pops hit empty", full_rejects, empty_rejects);
    if (fails == 0 && pending == 0)
      $display("circular_deque test passed");
    else
      $display("circular_deque test failed");
    $finish;
  end

endmodule
